// File: hdl/tppm_pkg.sv
// shared types and constants of the three phase power meter
package tppm_pkg;

  localparam int PHASES_DEF = 3;
  localparam int SAMPLE_BITS_DEF = 12;

  // configuration register indexes
  localparam logic [1:0] REG_VOLT_OFS = 2'd0;
  localparam logic [1:0] REG_CURR_OFS = 2'd1;
  localparam logic [1:0] REG_SHIFT    = 2'd2;
  localparam logic [1:0] REG_PERIODS  = 2'd3;

  localparam logic [31:0] ROOT_TOP = 32'h4000_0000;

  // controller to datapath commands
  typedef struct packed {
    logic acc;       // accumulate the held sweep
    logic per_load;  // load root operands for the selected phase
    logic root_step; // one root iteration
    logic per_fold;  // fold roots into report sums
    logic per_clr;   // clear period sums of the selected phase
    logic cnt_inc;   // bump period count
    logic div_load;  // load dividers for the selected phase
    logic div_step;  // one divide iteration
    logic rep_done;  // register output word, update energy, clear report sums
    logic cnt_clr;
    logic [1:0] ph;  // selected phase
  } tppm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic root_done;
    logic div_done;
    logic report_due;
  } tppm_sts_t;

endpackage

// File: hdl/three_phase_power_meter_core.sv
// top level of the three phase power meter
//  channel | direction | words
//  in_     | in        | one adc sweep
//  out_    | out       | one phase result, three per report
//  cfg_    | in        | one register write
// a sweep is captured and then accumulated; a period end adds root iteration and folding
// for each phase plus a check state, a report one-bit division and emit for each phase
// plus output stalls.
// in_ready is low while a sweep is being processed.
// reset is synchronous active low and clears all sums and the output valid flag.
// the output register holds a word until taken; emit waits while it is full.
module three_phase_power_meter_core #(
  parameter int PHASES = tppm_pkg::PHASES_DEF,
  parameter int SAMPLE_BITS = tppm_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_volt_a,
  input  logic signed [SAMPLE_BITS-1:0] in_volt_b,
  input  logic signed [SAMPLE_BITS-1:0] in_volt_c,
  input  logic signed [SAMPLE_BITS-1:0] in_curr_a,
  input  logic signed [SAMPLE_BITS-1:0] in_curr_b,
  input  logic signed [SAMPLE_BITS-1:0] in_curr_c,
  input  logic in_end_of_period,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_phase,
  output logic [15:0] out_rms_voltage,
  output logic [15:0] out_rms_current,
  output logic signed [31:0] out_real_power,
  output logic [31:0] out_apparent_power,
  output logic signed [63:0] out_energy,
  output logic out_last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import tppm_pkg::*;

  logic signed [7:0] volt_ofs_r, curr_ofs_r;
  logic [3:0] shift_r;
  logic [7:0] periods_r;
  tppm_cmd_t cmd;
  tppm_sts_t sts;
  logic busy, in_fire, out_load, last_ph, out_free;
  logic signed [2:0][SAMPLE_BITS-1:0] va, ca;
  logic signed [PHASES-1:0][SAMPLE_BITS-1:0] vin, cin;
  logic [15:0] r_u, r_i;
  logic signed [31:0] r_p;
  logic [31:0] r_s;
  logic signed [63:0] r_e;

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || out_ready;
  assign va = {in_volt_c, in_volt_b, in_volt_a};
  assign ca = {in_curr_c, in_curr_b, in_curr_a};
  assign vin = va[PHASES-1:0];
  assign cin = ca[PHASES-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_ofs_r <= '0; curr_ofs_r <= '0; shift_r <= 4'd6; periods_r <= 8'd50;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VOLT_OFS: volt_ofs_r <= cfg_data;
        REG_CURR_OFS: curr_ofs_r <= cfg_data;
        REG_SHIFT:    shift_r <= cfg_data[3:0];
        REG_PERIODS:  periods_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tppm_ctrl #(.PHASES(PHASES)) u_ctrl (
    .clk, .rst_n, .in_fire, .in_eop(in_end_of_period), .out_free, .sts, .cmd,
    .busy, .out_load, .out_last(last_ph)
  );

  tppm_datapath #(.PHASES(PHASES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst_n, .in_fire, .volt_in(vin), .curr_in(cin),
    .volt_ofs(volt_ofs_r), .curr_ofs(curr_ofs_r), .shift(shift_r), .periods(periods_r),
    .cmd, .sts, .res_urms(r_u), .res_irms(r_i), .res_power(r_p),
    .res_apparent(r_s), .res_energy(r_e)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (out_load) begin
      out_phase <= cmd.ph; out_rms_voltage <= r_u; out_rms_current <= r_i;
      out_real_power <= r_p; out_apparent_power <= r_s; out_energy <= r_e;
      out_last <= last_ph;
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_energy)))
    else $error("output word dropped");
  a_no_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free) else $error("output overwritten");
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready) else $error("sweep not taken into work");
`endif
endmodule

// File: hdl/tppm_ctrl.sv
// sequencer of the three phase power meter
module tppm_ctrl #(
  parameter int PHASES = tppm_pkg::PHASES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic in_eop,
  input  logic out_free,
  input  tppm_pkg::tppm_sts_t sts,
  output tppm_pkg::tppm_cmd_t cmd,
  output logic busy,
  output logic out_load,
  output logic out_last
);
  import tppm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_ROOT  = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic eop_r, eop_nxt;
  logic rootgo_r, rootgo_nxt;
  logic divgo_r, divgo_nxt;
  logic last_ph;

  assign last_ph = (ph_r == 2'(PHASES - 1));
  assign busy = (state_r != S_IDLE);
  assign out_last = last_ph;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ph_nxt = ph_r;
    eop_nxt = eop_r;
    rootgo_nxt = rootgo_r;
    divgo_nxt = divgo_r;
    cmd = '0;
    cmd.ph = ph_r;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          eop_nxt = in_eop;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        ph_nxt = '0;
        rootgo_nxt = 1'b0;
        state_nxt = eop_r ? S_ROOT : S_IDLE;
      end
      S_ROOT: begin
        if (!rootgo_r) begin
          cmd.per_load = 1'b1;
          rootgo_nxt = 1'b1;
        end else if (sts.root_done) begin
          state_nxt = S_FOLD;
        end else begin
          cmd.root_step = 1'b1;
        end
      end
      S_FOLD: begin
        cmd.per_fold = 1'b1;
        cmd.per_clr = 1'b1;
        rootgo_nxt = 1'b0;
        if (last_ph) begin
          cmd.cnt_inc = 1'b1;
          ph_nxt = '0;
          state_nxt = S_CHECK;
        end else begin
          ph_nxt = ph_r + 2'd1;
          state_nxt = S_ROOT;
        end
      end
      S_CHECK: begin
        divgo_nxt = 1'b0;
        state_nxt = sts.report_due ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (!divgo_r) begin
          cmd.div_load = 1'b1;
          divgo_nxt = 1'b1;
        end else if (sts.div_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          cmd.rep_done = 1'b1;
          divgo_nxt = 1'b0;
          if (last_ph) begin
            cmd.cnt_clr = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ph_nxt = ph_r + 2'd1;
            state_nxt = S_DIV;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r <= '0;
      eop_r <= 1'b0;
      rootgo_r <= 1'b0;
      divgo_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r <= ph_nxt;
      eop_r <= eop_nxt;
      rootgo_r <= rootgo_nxt;
      divgo_r <= divgo_nxt;
    end
  end

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r <= 2'(PHASES - 1)) else $error("phase index out of range");
  a_emit_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !out_free) |=> (state_r == S_EMIT && $stable(ph_r)))
    else $error("emit left without output space");
  a_idle_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && !eop_r) |=> state_r == S_IDLE)
    else $error("non period sweep did not return to idle");
`endif
endmodule

// File: hdl/tppm_datapath.sv
// accumulators, root unit and divider of the three phase power meter
module tppm_datapath #(
  parameter int PHASES = tppm_pkg::PHASES_DEF,
  parameter int SAMPLE_BITS = tppm_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic signed [PHASES-1:0][SAMPLE_BITS-1:0] volt_in,
  input  logic signed [PHASES-1:0][SAMPLE_BITS-1:0] curr_in,
  input  logic signed [7:0] volt_ofs,
  input  logic signed [7:0] curr_ofs,
  input  logic [3:0] shift,
  input  logic [7:0] periods,
  input  tppm_pkg::tppm_cmd_t cmd,
  output tppm_pkg::tppm_sts_t sts,
  output logic [15:0] res_urms,
  output logic [15:0] res_irms,
  output logic signed [31:0] res_power,
  output logic [31:0] res_apparent,
  output logic signed [63:0] res_energy
);
  import tppm_pkg::*;

  localparam int DW = SAMPLE_BITS + 1;

  logic signed [PHASES-1:0][SAMPLE_BITS-1:0] volt_r, curr_r;
  logic [47:0] vsq_r [PHASES];
  logic [47:0] isq_r [PHASES];
  logic signed [47:0] pw_r [PHASES];
  logic [39:0] rapp_r [PHASES];
  logic signed [39:0] rpw_r [PHASES];
  logic [23:0] ru_r [PHASES];
  logic [23:0] ri_r [PHASES];
  logic [63:0] en_r [PHASES];
  logic [7:0] cnt_r;

  // capture the sweep
  always_ff @(posedge clk) begin
    if (in_fire) begin
      volt_r <= volt_in;
      curr_r <= curr_in;
    end
  end

  // per-phase products of the held sweep
  logic [47:0] vsq_nxt [PHASES];
  logic [47:0] isq_nxt [PHASES];
  logic signed [47:0] pw_nxt [PHASES];
  always_comb begin
    logic signed [DW-1:0] u, i;
    logic signed [2*DW-1:0] uu, ii, ui;
    logic [48:0] su;
    logic signed [48:0] ss;
    for (int p = 0; p < PHASES; p++) begin
      u = DW'(signed'(volt_r[p])) - DW'(volt_ofs);
      i = DW'(signed'(curr_r[p])) - DW'(curr_ofs);
      uu = u * u;
      ii = i * i;
      ui = u * i;
      su = {1'b0, vsq_r[p]} + 49'(unsigned'(uu));
      vsq_nxt[p] = su[48] ? '1 : su[47:0];
      su = {1'b0, isq_r[p]} + 49'(unsigned'(ii));
      isq_nxt[p] = su[48] ? '1 : su[47:0];
      ss = 49'(pw_r[p]) - 49'(ui);
      if (ss[48] != ss[47]) pw_nxt[p] = ss[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      else pw_nxt[p] = ss[47:0];
    end
  end

  // two parallel root units, one phase at a time
  logic [31:0] urem_r, uroot_r, uplace_r, irem_r, iroot_r, iplace_r;
  logic [47:0] vsh, ish;
  logic [31:0] vop, iop;
  assign vsh = vsq_r[cmd.ph] >> shift;
  assign ish = isq_r[cmd.ph] >> shift;
  assign vop = (|vsh[47:32]) ? '1 : vsh[31:0];
  assign iop = (|ish[47:32]) ? '1 : ish[31:0];
  assign sts.root_done = (uplace_r == '0) && (iplace_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.per_load) begin
      urem_r <= vop; uroot_r <= '0; uplace_r <= ROOT_TOP;
      irem_r <= iop; iroot_r <= '0; iplace_r <= ROOT_TOP;
    end else if (cmd.root_step) begin
      // skipping leading places is equivalent to stepping through them with no subtract
      if (uplace_r != '0) begin
        if (urem_r >= uroot_r + uplace_r) begin
          urem_r <= urem_r - uroot_r - uplace_r;
          uroot_r <= (uroot_r + (uplace_r << 1)) >> 1;
        end else begin
          uroot_r <= uroot_r >> 1;
        end
        uplace_r <= uplace_r >> 2;
      end
      if (iplace_r != '0) begin
        if (irem_r >= iroot_r + iplace_r) begin
          irem_r <= irem_r - iroot_r - iplace_r;
          iroot_r <= (iroot_r + (iplace_r << 1)) >> 1;
        end else begin
          iroot_r <= iroot_r >> 1;
        end
        iplace_r <= iplace_r >> 2;
      end
    end
  end

  // roots of a 32-bit operand fit 16 bits, so their product fits 32 bits
  logic [31:0] ur, ir;
  assign ur = uroot_r;
  assign ir = iroot_r;
  logic [31:0] prod;
  assign prod = ur[15:0] * ir[15:0];
  logic signed [47:0] pwsh;
  assign pwsh = pw_r[cmd.ph] >>> shift;

  // sums of period and report, energy
  always_ff @(posedge clk) begin
    logic [40:0] a41;
    logic signed [48:0] s49;
    logic [24:0] a25;
    if (!rst_n) begin
      for (int p = 0; p < PHASES; p++) begin
        vsq_r[p] <= '0; isq_r[p] <= '0; pw_r[p] <= '0;
        rapp_r[p] <= '0; rpw_r[p] <= '0; ru_r[p] <= '0; ri_r[p] <= '0;
        en_r[p] <= '0;
      end
      cnt_r <= '0;
    end else begin
      if (cmd.acc) begin
        for (int p = 0; p < PHASES; p++) begin
          vsq_r[p] <= vsq_nxt[p];
          isq_r[p] <= isq_nxt[p];
          pw_r[p] <= pw_nxt[p];
        end
      end
      if (cmd.per_fold) begin
        a41 = {1'b0, rapp_r[cmd.ph]} + 41'(prod);
        rapp_r[cmd.ph] <= a41[40] ? '1 : a41[39:0];
        s49 = 49'(rpw_r[cmd.ph]) + 49'(pwsh);
        if (s49 > 49'sh7F_FFFF_FFFF) rpw_r[cmd.ph] <= 40'sh7F_FFFF_FFFF;
        else if (s49 < -49'sh80_0000_0000) rpw_r[cmd.ph] <= 40'sh80_0000_0000;
        else rpw_r[cmd.ph] <= s49[39:0];
        a25 = 25'(ru_r[cmd.ph]) + 25'(ur);
        ru_r[cmd.ph] <= (a25[24] || |ur[31:24]) ? '1 : a25[23:0];
        a25 = 25'(ri_r[cmd.ph]) + 25'(ir);
        ri_r[cmd.ph] <= (a25[24] || |ir[31:24]) ? '1 : a25[23:0];
      end
      if (cmd.per_clr) begin
        vsq_r[cmd.ph] <= '0; isq_r[cmd.ph] <= '0; pw_r[cmd.ph] <= '0;
      end
      if (cmd.cnt_inc) cnt_r <= cnt_r + 8'd1;
      if (cmd.rep_done) begin
        en_r[cmd.ph] <= en_r[cmd.ph] + 64'(signed'(rpw_r[cmd.ph]));
        rapp_r[cmd.ph] <= '0; rpw_r[cmd.ph] <= '0; ru_r[cmd.ph] <= '0; ri_r[cmd.ph] <= '0;
      end
      if (cmd.cnt_clr) cnt_r <= '0;
    end
  end

  logic [7:0] target;
  assign target = (periods == '0) ? 8'd1 : periods;
  assign sts.report_due = (cnt_r >= target);

  // restoring divider: four quotients share one divisor, one bit a cycle
  logic [7:0] dvs_r;
  logic [5:0] dcnt_r;
  logic [39:0] qa_r, qp_r;
  logic [23:0] qu_r, qi_r;
  logic [8:0] ra_r, rp_r, ru_rm, ri_rm;
  logic pneg_r;
  logic [39:0] pmag;
  assign pmag = rpw_r[cmd.ph][39] ? 40'(-rpw_r[cmd.ph]) : rpw_r[cmd.ph];
  assign sts.div_done = (dcnt_r == '0);

  always_ff @(posedge clk) begin
    logic [8:0] t;
    if (cmd.div_load) begin
      dvs_r <= (cnt_r == '0) ? 8'd1 : cnt_r;
      dcnt_r <= 6'd40;
      qa_r <= rapp_r[cmd.ph]; qp_r <= pmag;
      qu_r <= ru_r[cmd.ph]; qi_r <= ri_r[cmd.ph];
      ra_r <= '0; rp_r <= '0; ru_rm <= '0; ri_rm <= '0;
      pneg_r <= rpw_r[cmd.ph][39];
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 6'd1;
      t = {ra_r[7:0], qa_r[39]};
      if (t >= {1'b0, dvs_r}) begin ra_r <= t - {1'b0, dvs_r}; qa_r <= {qa_r[38:0], 1'b1}; end
      else begin ra_r <= t; qa_r <= {qa_r[38:0], 1'b0}; end
      t = {rp_r[7:0], qp_r[39]};
      if (t >= {1'b0, dvs_r}) begin rp_r <= t - {1'b0, dvs_r}; qp_r <= {qp_r[38:0], 1'b1}; end
      else begin rp_r <= t; qp_r <= {qp_r[38:0], 1'b0}; end
      if (dcnt_r <= 6'd24) begin
        t = {ru_rm[7:0], qu_r[23]};
        if (t >= {1'b0, dvs_r}) begin ru_rm <= t - {1'b0, dvs_r}; qu_r <= {qu_r[22:0], 1'b1}; end
        else begin ru_rm <= t; qu_r <= {qu_r[22:0], 1'b0}; end
        t = {ri_rm[7:0], qi_r[23]};
        if (t >= {1'b0, dvs_r}) begin ri_rm <= t - {1'b0, dvs_r}; qi_r <= {qi_r[22:0], 1'b1}; end
        else begin ri_rm <= t; qi_r <= {qi_r[22:0], 1'b0}; end
      end
    end
  end

  // result formatting
  logic signed [40:0] pq;
  assign pq = pneg_r ? -41'(qp_r) : 41'(qp_r);
  assign res_urms = qu_r[15:0];
  assign res_irms = qi_r[15:0];
  assign res_apparent = qa_r[31:0];
  assign res_power = (pq > 41'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                     (pq < -41'sh8000_0000) ? 32'sh8000_0000 : pq[31:0];
  assign res_energy = en_r[cmd.ph] + 64'(signed'(rpw_r[cmd.ph]));

`ifndef SYNTHESIS
  a_root_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.per_load |=> !sts.root_done) else $error("root unit not started");
  a_div_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_load |=> dcnt_r == 6'd40) else $error("divider not loaded");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> dvs_r != '0) else $error("zero divisor");
`endif
endmodule

// File: bench/tb.sv
// testbench of the three phase power meter core with a scoreboard predictor
`timescale 1ns / 100ps

module tb;
  import tppm_pkg::*;

  typedef struct {
    logic signed [11:0] volt [3];
    logic signed [11:0] curr [3];
    bit eop;
  } sweep_t;

  typedef struct {
    logic [1:0] phase;
    logic [15:0] urms;
    logic [15:0] irms;
    logic signed [31:0] power;
    logic [31:0] apparent;
    logic signed [63:0] energy;
    bit last;
  } meter_word_t;

  // predicts the per phase report words and checks the words from the block
  class power_scoreboard;
    int errors;
    meter_word_t pending_words[$];
    logic signed [7:0] volt_ofs, curr_ofs;
    logic [3:0] shift;
    logic [7:0] periods;
    longint unsigned vsq[3], isq[3], rep_app[3], rep_urms[3], rep_irms[3];
    longint pwr[3], rep_pwr[3];
    longint unsigned energy_acc[3];
    int unsigned count;

    function new();
      errors = 0;
      volt_ofs = 0;
      curr_ofs = 0;
      shift = 6;
      periods = 50;
      count = 0;
      for (int p = 0; p < 3; p++) begin
        vsq[p] = 0; isq[p] = 0; pwr[p] = 0; rep_app[p] = 0; rep_pwr[p] = 0;
        rep_urms[p] = 0; rep_irms[p] = 0; energy_acc[p] = 0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function longint unsigned clip_u(longint unsigned a, int bits);
      longint unsigned lim;
      lim = (64'd1 << bits) - 1;
      return (a > lim) ? lim : a;
    endfunction

    function longint clip_s(longint a, int bits);
      longint hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (a > hi) return hi;
      if (a < lo) return lo;
      return a;
    endfunction

    // digit by digit integer square root
    function longint unsigned root32(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'h4000_0000;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        REG_VOLT_OFS: volt_ofs = data;
        REG_CURR_OFS: curr_ofs = data;
        REG_SHIFT:    shift = data[3:0];
        REG_PERIODS:  periods = data;
        default: ;
      endcase
    endfunction

    function void note_sweep(sweep_t s);
      longint u, i, q, pw;
      longint unsigned vs, cs, ur, ir, cnt, target;
      meter_word_t w;
      // accumulate the sweep
      for (int p = 0; p < 3; p++) begin
        u = longint'(s.volt[p]) - longint'(volt_ofs);
        i = longint'(s.curr[p]) - longint'(curr_ofs);
        vsq[p] = clip_u(vsq[p] + longint'(u * u), 48);
        isq[p] = clip_u(isq[p] + longint'(i * i), 48);
        pwr[p] = clip_s(pwr[p] - u * i, 48);
      end
      if (!s.eop) return;
      // period end: roots and report sums
      for (int p = 0; p < 3; p++) begin
        vs = vsq[p] >> shift;
        cs = isq[p] >> shift;
        ur = root32((vs > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : vs);
        ir = root32((cs > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : cs);
        rep_app[p] = clip_u(rep_app[p] + ur * ir, 40);
        rep_pwr[p] = clip_s(rep_pwr[p] + (pwr[p] >>> shift), 40);
        rep_urms[p] = clip_u(rep_urms[p] + ur, 24);
        rep_irms[p] = clip_u(rep_irms[p] + ir, 24);
        vsq[p] = 0; isq[p] = 0; pwr[p] = 0;
      end
      count = (count + 1) & 8'hFF;
      target = (periods == 0) ? 1 : periods;
      if (count < target) return;
      // report
      cnt = (count == 0) ? 1 : count;
      for (int p = 0; p < 3; p++) begin
        q = rep_pwr[p] / longint'(cnt);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        energy_acc[p] = energy_acc[p] + longint'(rep_pwr[p]);
        w.phase = 2'(p);
        w.urms = 16'(rep_urms[p] / cnt);
        w.irms = 16'(rep_irms[p] / cnt);
        w.power = q[31:0];
        w.apparent = 32'(rep_app[p] / cnt);
        w.energy = energy_acc[p];
        w.last = (p == 2);
        pending_words.push_back(w);
        rep_app[p] = 0; rep_pwr[p] = 0; rep_urms[p] = 0; rep_irms[p] = 0;
      end
      count = 0;
    endfunction

    task check_word(meter_word_t got);
      meter_word_t exp_w;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word phase %0d", got.phase));
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.phase !== exp_w.phase)
        report($sformatf("phase %0d exp %0d", got.phase, exp_w.phase));
      if (got.urms !== exp_w.urms)
        report($sformatf("rms_voltage %0d exp %0d", got.urms, exp_w.urms));
      if (got.irms !== exp_w.irms)
        report($sformatf("rms_current %0d exp %0d", got.irms, exp_w.irms));
      if (got.power !== exp_w.power)
        report($sformatf("real_power %0d exp %0d", got.power, exp_w.power));
      if (got.apparent !== exp_w.apparent)
        report($sformatf("apparent_power %0d exp %0d", got.apparent, exp_w.apparent));
      if (got.energy !== exp_w.energy)
        report($sformatf("energy %0d exp %0d", got.energy, exp_w.energy));
      if (got.last !== exp_w.last)
        report($sformatf("last %0d exp %0d", got.last, exp_w.last));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [11:0] in_volt_a = 0, in_volt_b = 0, in_volt_c = 0;
  logic signed [11:0] in_curr_a = 0, in_curr_b = 0, in_curr_c = 0;
  logic in_end_of_period = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_phase;
  logic [15:0] out_rms_voltage, out_rms_current;
  logic signed [31:0] out_real_power;
  logic [31:0] out_apparent_power;
  logic signed [63:0] out_energy;
  logic out_last;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [7:0] cfg_data = 0;

  bit idle_on = 1;
  power_scoreboard meter_sb = new();

  three_phase_power_meter_core dut (.*);

  always #2 clk = ~clk;

  // result side: random stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        out_ready = 1;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end
    end
  end

  // check each accepted result word
  always @(posedge clk) begin
    meter_word_t w;
    if (rst_n && out_valid && out_ready) begin
      w.phase = out_phase;
      w.urms = out_rms_voltage;
      w.irms = out_rms_current;
      w.power = out_real_power;
      w.apparent = out_apparent_power;
      w.energy = out_energy;
      w.last = out_last;
      meter_sb.check_word(w);
    end
  end

  task send_sweep(sweep_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    @(negedge clk);
    in_valid = 1;
    in_volt_a = s.volt[0]; in_volt_b = s.volt[1]; in_volt_c = s.volt[2];
    in_curr_a = s.curr[0]; in_curr_b = s.curr[1]; in_curr_c = s.curr[2];
    in_end_of_period = s.eop;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    meter_sb.note_sweep(s);
  endtask

  task stop_sending();
    @(negedge clk);
    in_valid = 0;
  endtask

  // wait for all expected words, then let the block settle
  task drain();
    stop_sending();
    while (meter_sb.pending_words.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    meter_sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic sweep_t rand_sweep(int eop_odds);
    sweep_t s;
    for (int p = 0; p < 3; p++) begin
      s.volt[p] = 12'($urandom);
      s.curr[p] = 12'($urandom);
      if ($urandom_range(0, 9) == 0) s.volt[p] = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
      if ($urandom_range(0, 9) == 0) s.curr[p] = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
    end
    s.eop = ($urandom_range(0, eop_odds) == 0);
    return s;
  endfunction

  task send_random(int n, int eop_odds);
    for (int k = 0; k < n; k++) send_sweep(rand_sweep(eop_odds));
  endtask

  initial begin
    logic signed [11:0] edges [5];
    sweep_t s;
    edges = '{12'sh800, 12'sh7FF, 12'sh000, -12'sd1, 12'sd1};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: sample extremes, offsets at their limits, report every period
    write_reg(REG_VOLT_OFS, 8'h7F);
    write_reg(REG_CURR_OFS, 8'h80);
    write_reg(REG_SHIFT, 8'd0);
    write_reg(REG_PERIODS, 8'd1);
    for (int k = 0; k < 20; k++) begin
      for (int p = 0; p < 3; p++) begin
        s.volt[p] = edges[(k + p) % 5];
        s.curr[p] = edges[(k * 2 + p + 1) % 5];
      end
      s.eop = (k % 3 != 0);
      send_sweep(s);
    end
    drain();

    // opposite offsets, largest nominal shift, three periods per report
    write_reg(REG_VOLT_OFS, 8'h80);
    write_reg(REG_CURR_OFS, 8'h7F);
    write_reg(REG_SHIFT, 8'd12);
    write_reg(REG_PERIODS, 8'd3);
    send_random(80, 3);
    drain();

    // shift beyond the nominal range, zero period count treated as one
    write_reg(REG_VOLT_OFS, 8'h00);
    write_reg(REG_CURR_OFS, 8'h00);
    write_reg(REG_SHIFT, 8'd15);
    write_reg(REG_PERIODS, 8'd0);
    send_random(60, 2);
    drain();

    // long report interval, then lowered below the running count
    write_reg(REG_SHIFT, 8'd6);
    write_reg(REG_PERIODS, 8'd255);
    send_random(20, 1);
    drain();
    write_reg(REG_PERIODS, 8'd2);
    send_random(40, 3);
    // sender holds off until every expected word is out
    stop_sending();
    while (meter_sb.pending_words.size() > 0) @(posedge clk);
    send_random(40, 3);
    drain();

    // final stretch without idling
    write_reg(REG_VOLT_OFS, 8'($urandom));
    write_reg(REG_CURR_OFS, 8'($urandom));
    write_reg(REG_SHIFT, 8'($urandom_range(0, 12)));
    write_reg(REG_PERIODS, 8'($urandom_range(1, 3)));
    idle_on = 0;
    send_random(90, 3);
    drain();

    if (meter_sb.errors == 0 && meter_sb.pending_words.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// File: sim.f
hdl/tppm_pkg.sv
hdl/tppm_ctrl.sv
hdl/tppm_datapath.sv
hdl/three_phase_power_meter_core.sv
bench/tb.sv
